// ===== hw/rtl/hybrid_encoder_speed_estimator_core_assert.svh =====
// Assertion macros used by the checker of the speed estimator.
`ifndef HYBRID_ENCODER_SPEED_ESTIMATOR_CORE_ASSERT_SVH
`define HYBRID_ENCODER_SPEED_ESTIMATOR_CORE_ASSERT_SVH

// Clocked assertion that is switched off while the reset is asserted.
`define HESC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");

// Clocked assertion that is also evaluated while the reset is asserted.
`define HESC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: reset check failed");

`endif

// ===== hw/rtl/hesc_pkg.sv =====
// Package with the types, constants and codes of the speed estimator.
package hesc_pkg;

  localparam int unsigned MulW    = 52;
  localparam int unsigned MulBW   = 17;
  localparam int unsigned MulCntW = 5;
  localparam int unsigned DivNW   = 50;
  localparam int unsigned DivDW   = 48;
  localparam int unsigned DivCntW = 6;

  localparam logic [33:0] MinuteQ8 = 34'd15360000000;
  localparam logic [16:0] OneQ16   = 17'd65536;

  localparam logic [15:0] PprRst    = 16'd1;
  localparam logic [31:0] PeriodRst = 32'd100000;
  localparam logic [15:0] CenterRst = 16'd10;
  localparam logic [15:0] BandRst   = 16'd3;
  localparam logic [16:0] AlphaRst  = 17'd19661;

  typedef enum logic [2:0] {
    REG_PPR    = 3'd0,
    REG_PERIOD = 3'd1,
    REG_CENTER = 3'd2,
    REG_BAND   = 3'd3,
    REG_MODE   = 3'd4,
    REG_ALPHA  = 3'd5,
    REG_KEEP   = 3'd6
  } hesc_reg_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_EMA  = 2'd1,
    MODE_IIR  = 2'd2
  } hesc_mode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CDEN,
    ST_CNUM,
    ST_CDIV,
    ST_PCHK,
    ST_PDEN,
    ST_PNUM,
    ST_PDIV,
    ST_WT,
    ST_WDIV,
    ST_MIX,
    ST_RABS,
    ST_RRND,
    ST_FILT,
    ST_FMUL,
    ST_FABS,
    ST_FRND,
    ST_DONE
  } hesc_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hw/rtl/hesc_mul.sv =====
// Bit-serial shift-and-add multiplier with an initial addend, one multiplier bit per cycle.
module hesc_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hesc_pkg::MulW-1:0]    init_i,
  input  logic [hesc_pkg::MulW-1:0]    mcand_i,
  input  logic [hesc_pkg::MulBW-1:0]   mplier_i,
  output hesc_pkg::unit_stat_t         stat_o,
  output logic [hesc_pkg::MulW-1:0]    prod_o
);
  import hesc_pkg::*;

  logic [MulW-1:0]    acc_q, mc_q;
  logic [MulBW-1:0]   mb_q;
  logic [MulCntW-1:0] cnt_q;
  logic               busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MulCntW'(MulBW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MulCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= init_i;
      mc_q  <= mcand_i;
      mb_q  <= mplier_i;
    end else if (busy_q) begin
      if (mb_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= {mc_q[MulW-2:0], 1'b0};
      mb_q <= {1'b0, mb_q[MulBW-1:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

// ===== hw/rtl/hesc_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
module hesc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hesc_pkg::DivNW-1:0]   num_i,
  input  logic [hesc_pkg::DivDW-1:0]   den_i,
  output hesc_pkg::unit_stat_t         stat_o,
  output logic [hesc_pkg::DivNW-1:0]   quo_o
);
  import hesc_pkg::*;

  logic [DivNW-1:0]   num_q;
  logic [DivDW-1:0]   den_q, rem_q, rem_d;
  logic [DivDW:0]     trial;
  logic               ge;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;

  assign trial = {rem_q, num_q[DivNW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    if (ge) begin
      rem_d = DivDW'(trial - {1'b0, den_q});
    end else begin
      rem_d = trial[DivDW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivNW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[DivNW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = num_q;

endmodule

// ===== hw/rtl/hybrid_encoder_speed_estimator_core.sv =====
// Top level of the encoder speed estimator: registers, sequencer and result buffer.
//
// One beat on the s_axis channel carries a sample period's tick count and the time
// since the last edge in tdata, and the edge flag in tuser. The block turns it into
// one m_axis beat holding the smoothed and the unsmoothed speed, both signed Q24.8 RPM.
// A shared bit-serial multiplier (17 steps a product) and a shared restoring divider
// (50 steps a quotient) do all the arithmetic under a sequencer. The shortest path,
// taken when no edge was seen, the count speed lies outside the blend ramp and no
// smoothing step is due, skips the edge-period product and division, the weight division
// and the smoothing product. The block works on one beat at a time and takes no new
// beat until the sequencer is back in idle.
// s_axis_tready_o is high only while the sequencer is idle.
// The result sits in an output register, so a new beat is taken while the last result
// still waits; a stalled receiver holds the sequencer only when the next result is due.
// The user must write configuration registers via cfg_we_i, cfg_idx_i and cfg_data_i
// while the block is idle, which it does not enforce. Reset restores register defaults,
// clears the smoothing state and its seeded flag, and empties the output register.
module hybrid_encoder_speed_estimator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // tick_delta [15:0], since_edge_us [47:16]
  input  logic        s_axis_tuser_i,  // edge_seen
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o   // rpm_filtered [31:0], rpm_raw [63:32]
);
  import hesc_pkg::*;

  logic [15:0] ppr_q, center_q, band_q;
  logic [31:0] period_q;
  logic [1:0]  mode_q;
  logic [16:0] alpha_q, keep_q;

  logic [15:0] ppr_e, center_e, band_e;
  logic [31:0] period_e;
  logic [16:0] alpha_e, keep_e, wn;

  hesc_state_e state_q, state_d;
  logic        mul_go_d, mul_go_q, div_go_d, div_go_q;

  logic [15:0]      delta_q, dmag;
  logic [31:0]      since_q;
  logic             edge_q, neg;
  logic [DivDW-1:0] den_q;
  logic [DivNW-1:0] num_q;
  logic [31:0]      rc_q, rp_q, raw_q, sv_q, filt_q, sat_w, rnd_w;
  logic [16:0]      w_q;
  logic             seeded_q;
  logic [MulW-1:0]  mag_q;
  logic             rneg_q;
  logic [MulW-1:0]  rsum;

  logic [32:0] rc_ext, abs_rc;
  logic [33:0] abs34, lo_w, hi_w, wdiff;
  logic [17:0] cb_diff;
  logic [16:0] cb_sum;
  logic        at_lo, at_hi;

  logic [MulW-1:0]  mul_init, mul_mc, prod;
  logic [MulBW-1:0] mul_mb;
  logic [DivNW-1:0] quo;
  unit_stat_t       mul_st, div_st;

  logic        m_valid_q;
  logic [63:0] m_data_q;

  // Configuration registers and their effective values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q    <= PprRst;
      period_q <= PeriodRst;
      center_q <= CenterRst;
      band_q   <= BandRst;
      mode_q   <= MODE_NONE;
      alpha_q  <= AlphaRst;
      keep_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PPR:    ppr_q    <= cfg_data_i[15:0];
        REG_PERIOD: period_q <= cfg_data_i;
        REG_CENTER: center_q <= cfg_data_i[15:0];
        REG_BAND:   band_q   <= cfg_data_i[15:0];
        REG_MODE:   mode_q   <= cfg_data_i[1:0];
        REG_ALPHA:  alpha_q  <= cfg_data_i[16:0];
        REG_KEEP:   keep_q   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign ppr_e    = (ppr_q == '0) ? PprRst : ppr_q;
  assign period_e = (period_q == '0) ? PeriodRst : period_q;
  assign center_e = (center_q == '0) ? CenterRst : center_q;
  assign band_e   = (band_q == '0) ? BandRst : band_q;
  assign alpha_e  = (alpha_q == '0 || alpha_q > OneQ16) ? AlphaRst : alpha_q;
  assign keep_e   = (keep_q > OneQ16) ? OneQ16 : keep_q;
  assign wn       = (mode_q == MODE_EMA) ? alpha_e : 17'(OneQ16 - keep_e);

  // Sign, magnitude, saturation and rounding helpers.
  assign neg  = delta_q[15];
  assign dmag = neg ? 16'(16'd0 - delta_q) : delta_q;

  always_comb begin
    if (neg) begin
      sat_w = (quo > DivNW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(32'd0 - quo[31:0]);
    end else begin
      sat_w = (quo > DivNW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
    end
  end

  assign rsum  = mag_q + MulW'(32768);
  assign rnd_w = rneg_q ? 32'(32'd0 - rsum[47:16]) : rsum[47:16];

  assign rc_ext  = {rc_q[31], rc_q};
  assign abs_rc  = rc_q[31] ? 33'(33'd0 - rc_ext) : rc_ext;
  assign abs34   = {1'b0, abs_rc};
  assign cb_diff = 18'({2'b00, center_e}) - 18'({2'b00, band_e});
  assign cb_sum  = 17'({1'b0, center_e}) + 17'({1'b0, band_e});
  assign lo_w    = {{8{cb_diff[17]}}, cb_diff, 8'd0};
  assign hi_w    = {9'd0, cb_sum, 8'd0};
  assign at_lo   = $signed(abs34) <= $signed(lo_w);
  assign at_hi   = $signed(abs34) >= $signed(hi_w);
  assign wdiff   = abs34 - lo_w;

  // Multiplier operands follow the state that waits on the product.
  always_comb begin
    mul_init = '0;
    mul_mc   = '0;
    mul_mb   = '0;
    case (state_q)
      ST_CDEN, ST_PDEN: begin
        mul_mc = {20'd0, (state_q == ST_CDEN) ? period_e : since_q};
        mul_mb = {1'b0, ppr_e};
      end
      ST_CNUM: begin
        mul_init = {5'd0, den_q[DivDW-1:1]};
        mul_mc   = {18'd0, MinuteQ8};
        mul_mb   = {1'b0, dmag};
      end
      ST_MIX: begin
        mul_init = {{4{rp_q[31]}}, rp_q, 16'd0};
        mul_mc   = {{20{rc_q[31]}}, rc_q} - {{20{rp_q[31]}}, rp_q};
        mul_mb   = w_q;
      end
      ST_FMUL: begin
        mul_init = {{4{sv_q[31]}}, sv_q, 16'd0};
        mul_mc   = {{20{raw_q[31]}}, raw_q} - {{20{sv_q[31]}}, sv_q};
        mul_mb   = wn;
      end
      default: ;
    endcase
  end

  hesc_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_go_q),
    .init_i   (mul_init),
    .mcand_i  (mul_mc),
    .mplier_i (mul_mb),
    .stat_o   (mul_st),
    .prod_o   (prod)
  );

  hesc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .stat_o  (div_st),
    .quo_o   (quo)
  );

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mul_go_q <= mul_go_d;
      div_go_q <= div_go_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    mul_go_d = 1'b0;
    div_go_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d  = ST_CDEN;
          mul_go_d = 1'b1;
        end
      end
      ST_CDEN: begin
        if (mul_st.done) begin
          state_d  = ST_CNUM;
          mul_go_d = 1'b1;
        end
      end
      ST_CNUM: begin
        if (mul_st.done) begin
          state_d  = ST_CDIV;
          div_go_d = 1'b1;
        end
      end
      ST_CDIV: begin
        if (div_st.done) begin
          state_d = ST_PCHK;
        end
      end
      ST_PCHK: begin
        if (edge_q && since_q != '0) begin
          state_d  = ST_PDEN;
          mul_go_d = 1'b1;
        end else begin
          state_d = ST_WT;
        end
      end
      ST_PDEN: begin
        if (mul_st.done) begin
          state_d = ST_PNUM;
        end
      end
      ST_PNUM: begin
        state_d  = ST_PDIV;
        div_go_d = 1'b1;
      end
      ST_PDIV: begin
        if (div_st.done) begin
          state_d = ST_WT;
        end
      end
      ST_WT: begin
        if (at_lo || at_hi) begin
          state_d  = ST_MIX;
          mul_go_d = 1'b1;
        end else begin
          state_d  = ST_WDIV;
          div_go_d = 1'b1;
        end
      end
      ST_WDIV: begin
        if (div_st.done) begin
          state_d  = ST_MIX;
          mul_go_d = 1'b1;
        end
      end
      ST_MIX: begin
        if (mul_st.done) begin
          state_d = ST_RABS;
        end
      end
      ST_RABS: state_d = ST_RRND;
      ST_RRND: state_d = ST_FILT;
      ST_FILT: begin
        if (mode_q == MODE_NONE || !seeded_q) begin
          state_d = ST_DONE;
        end else begin
          state_d  = ST_FMUL;
          mul_go_d = 1'b1;
        end
      end
      ST_FMUL: begin
        if (mul_st.done) begin
          state_d = ST_FABS;
        end
      end
      ST_FABS: state_d = ST_FRND;
      ST_FRND: state_d = ST_DONE;
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          delta_q <= s_axis_tdata_i[15:0];
          since_q <= s_axis_tdata_i[47:16];
          edge_q  <= s_axis_tuser_i;
        end
      end
      ST_CDEN, ST_PDEN: begin
        if (mul_st.done) begin
          den_q <= prod[DivDW-1:0];
        end
      end
      ST_CNUM: begin
        if (mul_st.done) begin
          num_q <= prod[DivNW-1:0];
        end
      end
      ST_CDIV: begin
        if (div_st.done) begin
          rc_q <= sat_w;
        end
      end
      ST_PCHK: rp_q <= '0;
      ST_PNUM: num_q <= DivNW'(den_q[DivDW-1:1]) + DivNW'(MinuteQ8);
      ST_PDIV: begin
        if (div_st.done) begin
          rp_q <= sat_w;
        end
      end
      ST_WT: begin
        w_q   <= at_hi ? OneQ16 : '0;
        num_q <= {9'd0, wdiff[24:0], 16'd0};
        den_q <= {23'd0, band_e, 9'd0};
      end
      ST_WDIV: begin
        if (div_st.done) begin
          w_q <= quo[16:0];
        end
      end
      ST_RABS, ST_FABS: begin
        rneg_q <= prod[MulW-1];
        mag_q  <= prod[MulW-1] ? MulW'(MulW'(0) - prod) : prod;
      end
      ST_RRND: raw_q <= rnd_w;
      ST_FILT: filt_q <= raw_q;
      ST_FRND: filt_q <= rnd_w;
      default: ;
    endcase
  end

  // Smoothing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q     <= '0;
      seeded_q <= 1'b0;
    end else if (state_q == ST_FILT && mode_q != MODE_NONE && !seeded_q) begin
      sv_q     <= raw_q;
      seeded_q <= 1'b1;
    end else if (state_q == ST_FRND) begin
      sv_q <= rnd_w;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!m_valid_q || m_axis_tready_i)) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!m_valid_q || m_axis_tready_i)) begin
      m_data_q <= {raw_q, filt_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== hw/rtl/hesc_checker.sv =====
// Port-level checker of the speed estimator and its bind to the top level.
`include "hybrid_encoder_speed_estimator_core_assert.svh"

module hesc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o
);

  // A result beat held back by the receiver keeps its value.
  `HESC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // An accepted input beat occupies the block for at least the next cycle.
  `HESC_ASSERT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)

  // A new result only appears at the end of a busy interval.
  `HESC_ASSERT(a_result_from_work, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))

  // Reset empties the output and leaves the block ready.
  `HESC_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o && s_axis_tready_o)

endmodule

bind hybrid_encoder_speed_estimator_core hesc_checker u_hesc_checker (.*);
